### hdl/frt_pkg.sv
`default_nettype none
// Shared constants, derived widths and the controller-to-datapath command
// beat for the fragment reassembly tracker. No dependencies.

package frt_pkg;

    // Table and fragment geometry
    localparam int SLOTS            = 4;
    localparam int MAX_FRAGMENTS    = 64;
    localparam int FIRST_DATA_BYTES = 1024;
    localparam int DATA_BYTES       = 1024;

    // Fixed field widths
    localparam int ID_W   = 16;
    localparam int FIDX_W = 8;
    localparam int LEN_W  = 11;
    localparam int OFS_W  = 16;
    localparam int SIZE_W = 17;
    localparam int SLOT_OUT_W = 2;
    localparam int SIZE_MAX   = 131071;
    localparam int CAP_W      = 13;

    // Derived widths
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(MAX_FRAGMENTS);
    localparam int CNT_W  = $clog2(MAX_FRAGMENTS + 1);
    localparam int END_RAW_W =
        $clog2(FIRST_DATA_BYTES + (MAX_FRAGMENTS - 1) * DATA_BYTES + 1);
    // at least one bit above the size field so saturation can be tested
    localparam int END_W = (END_RAW_W > SIZE_W + 1) ? END_RAW_W : SIZE_W + 1;

    typedef struct packed {
        logic load;    // capture a fragment and run the lookup
        logic commit;  // read-modify-write of the chosen slot
    } frt_cmd_t;

endpackage

`default_nettype wire

### hdl/frt_ctrl.sv
`default_nettype none
// Sequencer of the fragment reassembly tracker: accepts a beat, runs the
// update step and raises the result strobe. Depends on frt_pkg.

module frt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output logic                 result_valid,
    output frt_pkg::frt_cmd_t    cmd
);
    import frt_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = 1'b0;
        cmd.load          = 1'b0;
        cmd.commit        = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                cmd.commit        = 1'b1;
                result_valid_next = 1'b1;
                state_next        = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg == EXEC);
    assign result_valid = result_valid_reg;

    // every accepted beat is followed by the EXEC update, then a return to idle with the result strobe
    a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy) else $error("load not followed by update cycle");
    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && result_valid)) else $error("update cycle overran");

endmodule

`default_nettype wire

### hdl/frt_datapath.sv
`default_nettype none
// Datapath of the fragment reassembly tracker: slot table, id lookup,
// offset and size arithmetic, completion check, result registers.
// Depends on frt_pkg.

module frt_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire frt_pkg::frt_cmd_t                cmd,
    input  wire logic [frt_pkg::ID_W-1:0]         message_id,
    input  wire logic [frt_pkg::FIDX_W-1:0]       fragment_index,
    input  wire logic [frt_pkg::FIDX_W-1:0]       fragments_after_first,
    input  wire logic [frt_pkg::LEN_W-1:0]        payload_bytes,
    output logic [frt_pkg::SLOT_OUT_W-1:0]        slot,
    output logic                                  new_slot,
    output logic [frt_pkg::OFS_W-1:0]             write_offset,
    output logic [frt_pkg::LEN_W-1:0]             write_length,
    output logic [frt_pkg::SIZE_W-1:0]            message_size,
    output logic                                  complete,
    output logic                                  dropped
);
    import frt_pkg::*;

    // slot table
    logic                     valid_reg [SLOTS];
    logic [ID_W-1:0]          id_reg    [SLOTS];
    logic [MAX_FRAGMENTS-1:0] map_reg   [SLOTS];
    logic [CNT_W-1:0]         cnt_reg   [SLOTS];
    logic [SIZE_W-1:0]        size_reg  [SLOTS];
    logic [SLOT_W-1:0]        next_reg;

    // captured fragment and lookup result
    logic                     drop_q;
    logic                     hit_q;
    logic [SLOT_W-1:0]        hit_idx_q;
    logic [ID_W-1:0]          id_q;
    logic [IDX_W-1:0]         idx_q;
    logic                     first_q;
    logic [CNT_W-1:0]         count_q;
    logic [OFS_W-1:0]         offset_q;
    logic [LEN_W-1:0]         len_q;
    logic [SIZE_W-1:0]        end_q;

    // result registers
    logic [SLOT_OUT_W-1:0]    slot_reg;
    logic                     new_slot_reg;
    logic [OFS_W-1:0]         offset_reg;
    logic [LEN_W-1:0]         length_reg;
    logic [SIZE_W-1:0]        size_out_reg;
    logic                     complete_reg;
    logic                     dropped_reg;

    // capture-side logic
    logic                     drop_c;
    logic                     hit_c;
    logic [SLOT_W-1:0]        hit_idx_c;
    logic [CAP_W-1:0]         cap_c;
    logic [LEN_W-1:0]         len_c;
    logic [END_W-1:0]         offset_c;
    logic [END_W-1:0]         end_c;
    logic [SIZE_W-1:0]        end_sat_c;

    always_comb
    begin
        drop_c = ({1'b0, fragment_index} >= (FIDX_W + 1)'(MAX_FRAGMENTS)) ||
                 ((fragment_index == '0) &&
                  ({1'b0, fragments_after_first} >= (FIDX_W + 1)'(MAX_FRAGMENTS)));

        // lowest matching slot wins
        hit_c     = 1'b0;
        hit_idx_c = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (id_reg[i] == message_id))
            begin
                hit_c     = 1'b1;
                hit_idx_c = SLOT_W'(i);
            end
        end

        cap_c = (fragment_index == '0) ? CAP_W'(FIRST_DATA_BYTES) : CAP_W'(DATA_BYTES);
        // when the cap is taken it is below payload_bytes, so it fits LEN_W
        len_c = ({{(CAP_W - LEN_W){1'b0}}, payload_bytes} > cap_c) ?
                cap_c[LEN_W-1:0] : payload_bytes;

        if (fragment_index == '0)
            offset_c = '0;
        else
            offset_c = END_W'(FIRST_DATA_BYTES) +
                       END_W'(fragment_index - FIDX_W'(1)) * END_W'(DATA_BYTES);
        end_c     = offset_c + END_W'(len_c);
        end_sat_c = (end_c > END_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : end_c[SIZE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            drop_q    <= drop_c;
            hit_q     <= hit_c;
            hit_idx_q <= hit_idx_c;
            id_q      <= message_id;
            idx_q     <= fragment_index[IDX_W-1:0];
            first_q   <= (fragment_index == '0);
            count_q   <= CNT_W'(fragments_after_first) + CNT_W'(1);
            offset_q  <= offset_c[OFS_W-1:0];
            len_q     <= len_c;
            end_q     <= end_sat_c;
        end
    end

    // update-side logic: a miss starts from a cleared slot
    logic [SLOT_W-1:0]        sel;
    logic [MAX_FRAGMENTS-1:0] base_map, map_n;
    logic [CNT_W-1:0]         base_cnt, cnt_a, cnt_n;
    logic [SIZE_W-1:0]        base_size, size_n;
    logic                     done_c;
    logic [SLOT_W-1:0]        next_adv;

    always_comb
    begin
        sel       = hit_q ? hit_idx_q : next_reg;
        base_map  = hit_q ? map_reg[sel]  : '0;
        base_cnt  = hit_q ? cnt_reg[sel]  : '0;
        base_size = hit_q ? size_reg[sel] : '0;

        cnt_a = (first_q && (count_q > base_cnt)) ? count_q : base_cnt;
        cnt_n = (CNT_W'(idx_q) >= cnt_a) ? CNT_W'(idx_q) + CNT_W'(1) : cnt_a;
        map_n = base_map | (MAX_FRAGMENTS'(1) << idx_q);
        size_n = (end_q > base_size) ? end_q : base_size;

        done_c = 1'b1;
        for (int i = 0; i < MAX_FRAGMENTS; i++)
        begin
            if ((CNT_W'(i) < cnt_n) && !map_n[i])
                done_c = 1'b0;
        end

        next_adv = (next_reg == SLOT_W'(SLOTS - 1)) ? '0 : next_reg + SLOT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                valid_reg[i] <= 1'b0;
            next_reg     <= '0;
            slot_reg     <= '0;
            new_slot_reg <= 1'b0;
            offset_reg   <= '0;
            length_reg   <= '0;
            size_out_reg <= '0;
            complete_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (drop_q)
            begin
                slot_reg     <= '0;
                new_slot_reg <= 1'b0;
                offset_reg   <= '0;
                length_reg   <= '0;
                size_out_reg <= '0;
                complete_reg <= 1'b0;
                dropped_reg  <= 1'b1;
            end
            else
            begin
                valid_reg[sel] <= !done_c;
                if (!hit_q)
                    next_reg <= next_adv;
                slot_reg     <= SLOT_OUT_W'(sel);
                new_slot_reg <= !hit_q;
                offset_reg   <= offset_q;
                length_reg   <= len_q;
                size_out_reg <= size_n;
                complete_reg <= done_c;
                dropped_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !drop_q)
        begin
            id_reg[sel]   <= id_q;
            map_reg[sel]  <= map_n;
            cnt_reg[sel]  <= cnt_n;
            size_reg[sel] <= size_n;
        end
    end

    assign slot         = slot_reg;
    assign new_slot     = new_slot_reg;
    assign write_offset = offset_reg;
    assign write_length = length_reg;
    assign message_size = size_out_reg;
    assign complete     = complete_reg;
    assign dropped      = dropped_reg;

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (!complete_reg && !new_slot_reg && (length_reg == '0) &&
                         (size_out_reg == '0)))
        else $error("dropped beat carries data");
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !drop_q && done_c) |=> !valid_reg[$past(sel)])
        else $error("completed slot still valid");
    a_miss_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !drop_q && !hit_q) |=>
            ((SLOTS == 1) || (next_reg != $past(next_reg))))
        else $error("replacement pointer stuck");

endmodule

`default_nettype wire

### hdl/fragment_reassembly_tracker.sv
`default_nettype none
// Top level of the fragment reassembly tracker: sequencer plus datapath.
// Depends on frt_pkg, frt_ctrl, frt_datapath.

// A fragment is taken on a clock edge where start is high and busy is low;
// busy then stays high while the matching slot is read, updated and
// written back in one read-modify-write on the slot table, and no new
// fragment is taken until busy is low again. The id lookup over all slots
// is done in the accept cycle itself. The result appears on the result
// ports for exactly one cycle with result_valid high, the first cycle with
// busy low again; there is no backpressure, so the receiver must take it
// then. A new fragment can be started in the same cycle that the previous
// result is shown. A fragment whose index, or, for the first fragment,
// whose header count is at or past the fragment limit leaves the table
// untouched and reports only dropped. A fragment whose id matches no live
// slot takes the slot under a round-robin pointer, whatever it held, and
// reports new_slot. complete means every fragment of the known count has
// arrived; that slot is then released for reuse.

module fragment_reassembly_tracker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [frt_pkg::ID_W-1:0]         message_id,
    input  wire logic [frt_pkg::FIDX_W-1:0]       fragment_index,
    input  wire logic [frt_pkg::FIDX_W-1:0]       fragments_after_first,
    input  wire logic [frt_pkg::LEN_W-1:0]        payload_bytes,
    output logic                                  result_valid,
    output logic [frt_pkg::SLOT_OUT_W-1:0]        slot,
    output logic                                  new_slot,
    output logic [frt_pkg::OFS_W-1:0]             write_offset,
    output logic [frt_pkg::LEN_W-1:0]             write_length,
    output logic [frt_pkg::SIZE_W-1:0]            message_size,
    output logic                                  complete,
    output logic                                  dropped
);
    import frt_pkg::*;

    // command beat from sequencer to datapath
    frt_cmd_t cmd;

    frt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    frt_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .message_id            (message_id),
        .fragment_index        (fragment_index),
        .fragments_after_first (fragments_after_first),
        .payload_bytes         (payload_bytes),
        .slot                  (slot),
        .new_slot              (new_slot),
        .write_offset          (write_offset),
        .write_length          (write_length),
        .message_size          (message_size),
        .complete              (complete),
        .dropped               (dropped)
    );

endmodule

`default_nettype wire
